// ===== design/assert_macros.svh =====
// assertion macros used by the hash table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked at the same clock edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/lpht_pkg.sv =====
// types, codes and default sizes of the linear probing hash table
package lpht_pkg;

	localparam int unsigned DEF_TABLE_ENTRIES = 4096;
	localparam int unsigned DEF_KEY_BITS      = 64;
	localparam int unsigned DEF_VALUE_BITS    = 64;

	localparam int unsigned FIELD_BITS  = 64;
	localparam int unsigned HASH_BITS   = 64;
	localparam int unsigned STATUS_BITS = 3;
	localparam int unsigned COUNT_BITS  = 12;

	// memory row: valid flag, hash, key, value
	localparam int unsigned DEF_ROW_BITS = 1 + HASH_BITS + DEF_KEY_BITS + DEF_VALUE_BITS;

	localparam logic MODE_PUT = 1'b0;
	localparam logic MODE_GET = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic                  mode;
		logic [FIELD_BITS-1:0] key;
		logic [HASH_BITS-1:0]  key_hash;
		logic [FIELD_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [FIELD_BITS-1:0]  read_value;
		logic [COUNT_BITS-1:0]  entry_count;
	} rsp_t;

endpackage

// ===== design/lpht_slot_mem.sv =====
// slot memory with one write port and one read port, registered read data
module lpht_slot_mem #(
	parameter int unsigned DEPTH = lpht_pkg::DEF_TABLE_ENTRIES,
	parameter int unsigned ROW_W = lpht_pkg::DEF_ROW_BITS
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ROW_W-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [ROW_W-1:0]         rd_data
);
	import lpht_pkg::*;

	logic [ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/lpht_hash_mod.sv =====
// reduces a hash to a home slot index: mask for power of two sizes, else eight bits a cycle
module lpht_hash_mod #(
	parameter int unsigned TABLE_ENTRIES = lpht_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lpht_pkg::HASH_BITS-1:0]   hash,
	output logic                             done,
	output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);
	import lpht_pkg::*;

	localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
	localparam bit          IS_POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam int unsigned STEP_BITS = 8;
	localparam int unsigned STEPS    = HASH_BITS / STEP_BITS;
	localparam int unsigned STEP_W   = $clog2(STEPS);

	logic             done_q;
	logic [IDX_W-1:0] idx_q;

	assign done = done_q;
	assign idx  = idx_q;

	generate
		if (IS_POW2) begin : g_mask
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= hash[IDX_W-1:0];
				end
			end
		end else begin : g_serial
			localparam logic [IDX_W:0] NMOD = (IDX_W + 1)'(TABLE_ENTRIES);

			logic                 run_q;
			logic [STEP_W-1:0]    step_q;
			logic [HASH_BITS-1:0] hash_q;
			logic [IDX_W-1:0]     rem_next;

			// restoring remainder over the top byte of the shifted hash
			always_comb begin
				logic [IDX_W:0]   part;
				logic [IDX_W-1:0] rem;
				rem = idx_q;
				for (int i = 0; i < STEP_BITS; i++) begin
					part = {rem, hash_q[HASH_BITS-1-i]};
					if (part >= NMOD) begin
						part = part - NMOD;
					end
					rem = part[IDX_W-1:0];
				end
				rem_next = rem;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					done_q <= 1'b0;
					step_q <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						run_q  <= 1'b1;
						step_q <= '0;
					end else if (run_q) begin
						step_q <= step_q + 1'b1;
						if (step_q == STEP_W'(STEPS - 1)) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					hash_q <= hash;
					idx_q  <= '0;
				end else if (run_q) begin
					hash_q <= hash_q << STEP_BITS;
					idx_q  <= rem_next;
				end
			end
		end
	endgenerate

endmodule

// ===== design/linear_probing_hash_table.sv =====
// linear probing hash table: sequencer, probe compare and result register
//
//   channel | signals                      | transaction
//   --------+------------------------------+--------------------------------------
//   request | req_valid, req_ready, req    | put (mode 0) or lookup (mode 1) of a key
//   result  | rsp_valid, rsp_ready, rsp    | status, read value, occupied entry count
//
// after reset the slot memory is swept clear, one slot a cycle, and req_ready stays
// low until every slot has been cleared
// after acceptance a request goes through the hash reduction, a slot memory read, a
// compare for each probed slot (one slot memory read per cycle) and a final step; a
// table size that is not a power of two reduces the hash byte by byte
// one request is worked on at a time; a finished result waits in the output register
// and a later request stalls in its last step only while that register is still full
`include "assert_macros.svh"

module linear_probing_hash_table #(
	parameter int unsigned TABLE_ENTRIES = lpht_pkg::DEF_TABLE_ENTRIES,
	parameter int unsigned KEY_BITS      = lpht_pkg::DEF_KEY_BITS,
	parameter int unsigned VALUE_BITS    = lpht_pkg::DEF_VALUE_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lpht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lpht_pkg::rsp_t rsp
);
	import lpht_pkg::*;

	localparam int unsigned IDX_W      = $clog2(TABLE_ENTRIES);
	localparam int unsigned FILL_LIMIT = TABLE_ENTRIES / 2;
	localparam int unsigned CNT_W      = $clog2(FILL_LIMIT + 1);
	localparam int unsigned ROW_W      = 1 + HASH_BITS + KEY_BITS + VALUE_BITS;

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	typedef struct packed {
		logic                  valid;
		logic [HASH_BITS-1:0]  hash;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} row_t;

	logic [2:0]            state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      count_q;
	req_t                  item_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] found_value_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// hash reduction
	logic             mod_start;
	logic             mod_done;
	logic [IDX_W-1:0] mod_idx;

	// slot memory port
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_rd_addr;
	row_t             mem_wr_row;
	row_t             mem_rd_row;

	logic             req_fire;
	logic [IDX_W-1:0] next_idx;
	logic             row_match;
	logic             probe_end;
	logic             fin_go;
	logic             fin_write;
	logic             fin_insert;
	logic [CNT_W-1:0] fin_count;
	rsp_t             fin_rsp;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign mod_start = req_fire;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	lpht_hash_mod #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_hash_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.hash  (req.key_hash),
		.done  (mod_done),
		.idx   (mod_idx)
	);

	// probe walk wraps at the table end
	assign next_idx = (idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;

	// during a probe the next slot is fetched ahead, so the compare of one slot overlaps the read of the next
	assign mem_rd_addr = (state_q == S_CMP) ? next_idx : idx_q;

	assign row_match = mem_rd_row.valid && (mem_rd_row.hash == item_q.key_hash) &&
		(mem_rd_row.key == item_q.key[KEY_BITS-1:0]);
	assign probe_end = !mem_rd_row.valid || row_match;

	// the result register must be free, or be taken now, before the item completes
	assign fin_go = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);

	// outcome of a finished walk
	always_comb begin
		fin_write  = 1'b0;
		fin_insert = 1'b0;
		fin_count  = count_q;
		fin_rsp.read_value  = '0;
		if (item_q.mode == MODE_PUT) begin
			if (hit_q) begin
				fin_write      = 1'b1;
				fin_rsp.status = ST_UPDATED;
			end else if (count_q >= CNT_W'(FILL_LIMIT)) begin
				fin_rsp.status = ST_FULL;
			end else begin
				fin_write      = 1'b1;
				fin_insert     = 1'b1;
				fin_count      = count_q + 1'b1;
				fin_rsp.status = ST_INSERTED;
			end
		end else begin
			if (hit_q) begin
				fin_rsp.status     = ST_FOUND;
				fin_rsp.read_value = FIELD_BITS'(found_value_q);
			end else begin
				fin_rsp.status = ST_NOT_FOUND;
			end
		end
		fin_rsp.entry_count = COUNT_BITS'(fin_count);
	end

	// memory write: clearing sweep, or insert / update at the slot that ended the walk
	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_wr_en  = 1'b1;
			mem_wr_row = '0;
		end else begin
			mem_wr_en        = fin_go && fin_write;
			mem_wr_row.valid = 1'b1;
			mem_wr_row.hash  = item_q.key_hash;
			mem_wr_row.key   = item_q.key[KEY_BITS-1:0];
			mem_wr_row.value = item_q.value[VALUE_BITS-1:0];
		end
	end

	lpht_slot_mem #(
		.DEPTH(TABLE_ENTRIES),
		.ROW_W(ROW_W)
	) u_slot_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(idx_q),
		.wr_data(mem_wr_row),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_row)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a result taken in the cycle a new one is loaded keeps valid high
			if (rsp_valid_q && rsp_ready && !fin_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= next_idx;
					if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						idx_q   <= mod_idx;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (probe_end) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= next_idx;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						rsp_valid_q <= 1'b1;
						count_q     <= fin_count;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req;
		end
		if ((state_q == S_CMP) && probe_end) begin
			hit_q         <= row_match;
			found_value_q <= mem_rd_row.value;
		end
		if (fin_go) begin
			rsp_q <= fin_rsp;
		end
	end

	`ASSERT_ALWAYS(a_count_limit, count_q <= CNT_W'(FILL_LIMIT), "count over limit")
	`ASSERT_IMPLY(a_count_step, !$stable(count_q), count_q == CNT_W'($past(count_q) + 1'b1), "count jump")
	`ASSERT_IMPLY(a_write_state, mem_wr_en, (state_q == S_CLEAR) || (state_q == S_FIN), "stray write")
	`ASSERT_IMPLY(a_insert_room, fin_go && fin_insert, count_q < CNT_W'(FILL_LIMIT), "insert when full")
	`ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid_q), $past(state_q) == S_FIN, "stray result")

endmodule
